// File: hw/rtl/sacf_pkg.sv
// sacf_pkg: types and constants for the checked frame builder
// no dependencies; imported by sum_add_check_frame_builder_unit
package sacf_pkg;

    localparam int FRAME_BYTES   = 19;
    localparam int CHECKED_BYTES = 16;
    localparam int IDX_W         = 5;

    localparam logic [7:0] LEN_BYTE        = 8'h0F;
    localparam logic [7:0] FRAME_HEAD_RST  = 8'hAA;
    localparam logic [7:0] DEST_ADDR_RST   = 8'hFF;
    localparam logic [7:0] FRAME_ID_RST    = 8'h80;

    // frame byte positions
    localparam logic [IDX_W-1:0] POS_HEAD    = 5'd0;
    localparam logic [IDX_W-1:0] POS_DEST    = 5'd1;
    localparam logic [IDX_W-1:0] POS_ID      = 5'd2;
    localparam logic [IDX_W-1:0] POS_LEN     = 5'd3;
    localparam logic [IDX_W-1:0] POS_PAYLOAD = 5'd4;
    localparam logic [IDX_W-1:0] POS_SUM     = 5'd16;
    localparam logic [IDX_W-1:0] POS_ADD     = 5'd17;
    localparam logic [IDX_W-1:0] POS_LAST    = 5'd18;

    // register index in paddr[3:2]
    typedef enum logic [1:0] {
        REG_FRAME_HEAD = 2'd0,
        REG_DEST_ADDR  = 2'd1,
        REG_FRAME_ID   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] x_word;
        logic [31:0] y_word;
        logic [31:0] z_word;
        logic [7:0]  trailer_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } out_t;

endpackage

// File: hw/rtl/sum_add_check_frame_builder_unit.sv
// sum_add_check_frame_builder_unit: turns one word triple into a 19-byte checked frame
// depends on sacf_pkg (payload structs, byte positions, register codes)
//
// channel | dir | handshake                  | payload
// in      | in  | in_valid / in_ready        | in_data  (in_t: x, y, z words, trailer)
// out     | out | out_valid / out_ready      | out_data (out_t: tx_byte, last_byte)
// apb     | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// a frame goes out one byte at a time through the one-byte output register
// the next item is taken in the cycle the final byte of the current frame is loaded
// so frames follow each other with no gap
// reset clears busy flag, byte counter, output valid; presets the config registers
// a stall on out holds the output register and freezes the byte counter
module sum_add_check_frame_builder_unit
    import sacf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    // byte channel
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic [7:0] frame_head_reg;
    logic [7:0] dest_addr_reg;
    logic [7:0] frame_id_reg;

    // frame being sent
    in_t              item_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       add_reg;

    // output register
    logic             out_valid_reg;
    out_t             out_reg;

    logic             load_out;
    logic             advance;
    logic             in_take;
    logic [7:0]       cur_byte;
    logic [7:0]       sum_next;
    logic [7:0]       add_next;
    logic [95:0]      payload;
    logic [3:0]       pay_off;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_head_reg <= FRAME_HEAD_RST;
            dest_addr_reg  <= DEST_ADDR_RST;
            frame_id_reg   <= FRAME_ID_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_FRAME_HEAD: frame_head_reg <= pwdata[7:0];
                REG_DEST_ADDR:  dest_addr_reg  <= pwdata[7:0];
                REG_FRAME_ID:   frame_id_reg   <= pwdata[7:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_HEAD: prdata = {24'd0, frame_head_reg};
            REG_DEST_ADDR:  prdata = {24'd0, dest_addr_reg};
            REG_FRAME_ID:   prdata = {24'd0, frame_id_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // output register takes a byte when empty or when its byte is being transferred
    assign load_out = !out_valid_reg || out_ready;
    assign advance  = busy_reg && load_out;
    // free, or the final byte of this frame is loaded into the output register this cycle
    assign in_ready = !busy_reg || (advance && (idx_reg == POS_LAST));
    assign in_take  = in_valid && in_ready;

    // payload bytes, x word first, each least significant byte first
    assign payload = {item_reg.z_word, item_reg.y_word, item_reg.x_word};
    assign pay_off = idx_reg[3:0] - POS_PAYLOAD[3:0];

    always_comb
    begin
        case (idx_reg)
            POS_HEAD: cur_byte = frame_head_reg;
            POS_DEST: cur_byte = dest_addr_reg;
            POS_ID:   cur_byte = frame_id_reg;
            POS_LEN:  cur_byte = LEN_BYTE;
            POS_SUM:  cur_byte = sum_reg;
            POS_ADD:  cur_byte = add_reg;
            POS_LAST: cur_byte = item_reg.trailer_byte;
            default:  cur_byte = payload[8*pay_off +: 8];
        endcase
    end

    // running checks, built as the first sixteen bytes go out
    assign sum_next = sum_reg + cur_byte;
    assign add_next = add_reg + sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                if (idx_reg == POS_LAST)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end

            if (load_out)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    // payload side, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
            sum_reg  <= 8'd0;
            add_reg  <= 8'd0;
        end
        else if (advance && (idx_reg < POS_SUM))
        begin
            sum_reg <= sum_next;
            add_reg <= add_next;
        end

        if (advance)
        begin
            out_reg.tx_byte   <= cur_byte;
            out_reg.last_byte <= (idx_reg == POS_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks

    a_take_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && busy_reg) |-> (advance && idx_reg == POS_LAST))
        else $error("item taken in the middle of a frame");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= POS_LAST)
        else $error("byte counter past frame end");

    a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> idx_reg == '0)
        else $error("byte counter not cleared while idle");

    a_sum_byte_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_reg == POS_SUM) |=> out_data.tx_byte == $past(sum_reg))
        else $error("sum check byte not loaded from its accumulator");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_reg != POS_LAST) |=> !out_data.last_byte)
        else $error("last flag on an inner frame byte");

endmodule
